// File: rtl/idle_gap_packet_filter_top_macros.svh
// Assertion macros shared by the idle-gap packet filter RTL.
`ifndef IDLE_GAP_PACKET_FILTER_TOP_MACROS_SVH
`define IDLE_GAP_PACKET_FILTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IGPF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("igpf assertion failed");
`define IGPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("igpf assertion failed");
`else
`define IGPF_ASSERT_SAME(label, ante, cons)
`define IGPF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/igpf_pkg.sv
// Types, constants and register map of the idle-gap packet filter.
package igpf_pkg;

    localparam int BUF_DEPTH_DEF = 64;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;
    localparam int IDLE_W    = 17;

    localparam logic [REG_IDX_W-1:0] REG_GAP_TIMEOUT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SLEEP_TIMEOUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RPM       = 2'd2;

    localparam logic [7:0]  GAP_TIMEOUT_RST   = 8'd15;
    localparam logic [15:0] SLEEP_TIMEOUT_RST = 16'd60000;
    localparam logic [15:0] MAX_RPM_RST       = 16'd242;

    localparam logic [7:0] CMD_START_REQUEST = 8'h11;
    localparam logic [7:0] CMD_START_INFO    = 8'h16;
    localparam logic [7:0] ARG_MAX_RPM       = 8'h1F;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [2:0] SUBST_LEN = 3'd5;

    typedef struct packed {
        logic [7:0]  gap_timeout_ms;
        logic [15:0] sleep_timeout_ms;
        logic [15:0] max_rpm_value;
    } igpf_cfg_t;

endpackage

// File: rtl/idle_gap_packet_filter_top.sv
// Top level of the idle-gap packet filter: buffer, timers, emit sequencer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | req_type, rx_byte
//  out     | output    | out_valid/out_stall| tx_byte, has_byte, last, shutdown
//  cfg     | input     | APB psel/penable   | paddr, pwdata, prdata
//
// A byte or a tick that closes nothing is handled in the idle state.
// An emitted packet takes, per byte, a buffer read (FETCH), then an output load
// (SEND) through the checksum adder; a shutdown report uses the REPORT state.
// Reset clears counters, flags and the output valid; datapath and buffer contents are undefined.
// A stalled output holds the sequencer; input stalls while a packet or report is sent.
`include "idle_gap_packet_filter_top_macros.svh"

module idle_gap_packet_filter_top
    import igpf_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        tx_byte,
    output logic              has_byte,
    output logic              last,
    output logic              shutdown,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(BUF_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_SEND   = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    igpf_cfg_t cfg;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic               pending_reg, pending_next;
    logic [7:0]         gap_reg, gap_next;
    logic [IDLE_W-1:0]  idle_reg, idle_next;
    logic               stopped_reg, stopped_next;
    logic               out_valid_reg, out_valid_next;

    logic [7:0]         cmd_reg, cmd_next;
    logic [7:0]         arg_reg, arg_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic               subst_reg, subst_next;
    logic               sd_reg, sd_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         tx_byte_reg, tx_byte_next;
    logic               has_byte_reg, has_byte_next;
    logic               last_reg, last_next;
    logic               shutdown_reg, shutdown_next;
    logic [7:0]         rd_data_reg;

    logic [7:0]         mem [BUF_DEPTH];

    logic               in_fire;
    logic               slot_free;
    logic               room;
    logic               wr_en;
    logic [IDLE_W-1:0]  idle_inc;
    logic               stop_now;
    logic               close_now;
    logic               subst_now;
    logic               fwd_now;
    logic [7:0]         byte_sel;
    logic               last_sel;

    igpf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign room      = (byte_count_reg < CNT_W'(BUF_DEPTH));
    assign wr_en     = in_fire && !stopped_reg && (req_type == REQ_BYTE) && room;

    assign idle_inc  = (idle_reg == {IDLE_W{1'b1}}) ? idle_reg : idle_reg + 1'b1;
    assign stop_now  = (idle_inc > {1'b0, cfg.sleep_timeout_ms});
    assign close_now = pending_reg && (gap_reg >= cfg.gap_timeout_ms);
    assign subst_now = (byte_count_reg >= CNT_W'(2)) && (cmd_reg == CMD_START_INFO)
                       && (arg_reg == ARG_MAX_RPM);
    assign fwd_now   = (cmd_reg == CMD_START_REQUEST) || (cmd_reg == CMD_START_INFO);

    always_comb
    begin
        if (subst_reg)
        begin
            unique case (idx_reg[2:0])
                3'd0:    byte_sel = CMD_START_INFO;
                3'd1:    byte_sel = ARG_MAX_RPM;
                3'd2:    byte_sel = cfg.max_rpm_value[15:8];
                3'd3:    byte_sel = cfg.max_rpm_value[7:0];
                default: byte_sel = sum_reg;
            endcase
        end
        else
        begin
            byte_sel = rd_data_reg;
        end
    end

    assign last_sel = ({1'b0, idx_reg} + CNT_W'(1)) == len_reg;

    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        pending_next    = pending_reg;
        gap_next        = gap_reg;
        idle_next       = idle_reg;
        stopped_next    = stopped_reg;
        cmd_next        = cmd_reg;
        arg_next        = arg_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        subst_next      = subst_reg;
        sd_next         = sd_reg;
        sum_next        = sum_reg;
        tx_byte_next    = tx_byte_reg;
        has_byte_next   = has_byte_reg;
        last_next       = last_reg;
        shutdown_next   = shutdown_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (stopped_reg)
                    begin
                        state_next = ST_REPORT;
                    end
                    else if (req_type == REQ_BYTE)
                    begin
                        if (room)
                        begin
                            if (byte_count_reg == CNT_W'(0))
                                cmd_next = rx_byte;
                            if (byte_count_reg == CNT_W'(1))
                                arg_next = rx_byte;
                            byte_count_next = byte_count_reg + 1'b1;
                            pending_next    = 1'b1;
                            gap_next        = '0;
                            idle_next       = '0;
                        end
                    end
                    else
                    begin
                        idle_next = idle_inc;
                        if (stop_now)
                            stopped_next = 1'b1;
                        if (close_now)
                        begin
                            pending_next    = 1'b0;
                            byte_count_next = '0;
                            gap_next        = '0;
                        end
                        else if (pending_reg)
                        begin
                            gap_next = gap_reg + 1'b1;
                        end
                        idx_next   = '0;
                        sum_next   = '0;
                        subst_next = subst_now;
                        sd_next    = stop_now;
                        len_next   = subst_now ? CNT_W'(SUBST_LEN) : byte_count_reg;
                        priority if (close_now && (subst_now || fwd_now))
                            state_next = ST_FETCH;
                        else if (stop_now)
                            state_next = ST_REPORT;
                        else
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = byte_sel;
                    has_byte_next  = 1'b1;
                    last_next      = last_sel;
                    shutdown_next  = last_sel && sd_reg;
                    sum_next       = sum_reg + byte_sel;
                    if (last_sel)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = '0;
                    has_byte_next  = 1'b0;
                    last_next      = 1'b1;
                    shutdown_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_count_reg <= '0;
            pending_reg    <= 1'b0;
            gap_reg        <= '0;
            idle_reg       <= '0;
            stopped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            pending_reg    <= pending_next;
            gap_reg        <= gap_next;
            idle_reg       <= idle_next;
            stopped_reg    <= stopped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        arg_reg      <= arg_next;
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        subst_reg    <= subst_next;
        sd_reg       <= sd_next;
        sum_reg      <= sum_next;
        tx_byte_reg  <= tx_byte_next;
        has_byte_reg <= has_byte_next;
        last_reg     <= last_next;
        shutdown_reg <= shutdown_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[byte_count_reg[IDX_W-1:0]] <= rx_byte;
        if (state_reg == ST_FETCH)
            rd_data_reg <= mem[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign has_byte  = has_byte_reg;
    assign last      = last_reg;
    assign shutdown  = shutdown_reg;

    `IGPF_ASSERT_NEXT(a_stopped_sticks, stopped_reg, stopped_reg)
    `IGPF_ASSERT_SAME(a_shutdown_implies_stopped, out_valid_reg && shutdown_reg, stopped_reg)
    `IGPF_ASSERT_SAME(a_count_bounded, 1'b1, byte_count_reg <= CNT_W'(BUF_DEPTH))
    `IGPF_ASSERT_SAME(a_fetch_in_range, state_reg == ST_FETCH, CNT_W'(idx_reg) < len_reg)
    `IGPF_ASSERT_NEXT(a_last_ends_packet, (state_reg == ST_SEND) && slot_free && last_sel,
                      (state_reg == ST_IDLE) && out_valid_reg && last_reg)

endmodule

// File: rtl/igpf_cfg.sv
// APB configuration registers of the idle-gap packet filter.
module igpf_cfg
    import igpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output igpf_cfg_t         cfg
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    igpf_cfg_t            cfg_reg;
    igpf_cfg_t            cfg_next;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_GAP_TIMEOUT:   cfg_next.gap_timeout_ms   = pwdata[7:0];
                REG_SLEEP_TIMEOUT: cfg_next.sleep_timeout_ms = pwdata[15:0];
                REG_MAX_RPM:       cfg_next.max_rpm_value    = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAP_TIMEOUT:   prdata = {{(DATA_W-8){1'b0}}, cfg_reg.gap_timeout_ms};
            REG_SLEEP_TIMEOUT: prdata = {{(DATA_W-16){1'b0}}, cfg_reg.sleep_timeout_ms};
            REG_MAX_RPM:       prdata = {{(DATA_W-16){1'b0}}, cfg_reg.max_rpm_value};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_timeout_ms   <= GAP_TIMEOUT_RST;
            cfg_reg.sleep_timeout_ms <= SLEEP_TIMEOUT_RST;
            cfg_reg.max_rpm_value    <= MAX_RPM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
